FILE: design/palc_pkg.sv
// Package: types, constants and widths shared by the arc-length clip unit.
package palc_pkg;

    localparam int COORD_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int LENGTH_BITS = 40;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               first_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               is_last;
        logic               window_closed;
    } t_out_item;

    typedef enum logic [0:0] {
        REG_START = 1'b0,
        REG_END   = 1'b1
    } t_reg_index;

    // Classified vertex handed from front to back.
    typedef struct packed {
        logic               restart;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_job;

endpackage

FILE: design/palc_front.sv
// Front part: accepts vertices and a short queue of classified jobs.
module palc_front
    import palc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    output logic     o_job_valid,
    input  logic     i_job_ready,
    output t_job     o_job
);

    t_job       r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       r_have_prev;
    logic       push, pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_have_prev <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_wp].restart <= i_data.first_vertex || !r_have_prev;
                r_q[r_wp].x <= i_data.point_x;
                r_q[r_wp].y <= i_data.point_y;
                r_wp <= ~r_wp;
                r_have_prev <= 1'b1;
            end
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> r_cnt == 2'd2) else $error("queue lost entry");
    a_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("pointer mismatch");

endmodule

FILE: design/palc_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module palc_sqrt #(
    parameter int IN_BITS  = 66,
    parameter int OUT_BITS = 33
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [IN_BITS-1:0]  i_val,
    output logic                o_done,
    output logic [OUT_BITS-1:0] o_root
);

    localparam int CW = $clog2(OUT_BITS + 1);
    localparam int RW = IN_BITS + 2;

    logic [RW-1:0]       r_rem;
    logic [IN_BITS-1:0]  r_src;
    logic [OUT_BITS-1:0] r_root;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic [RW-1:0]       shifted, trial;

    assign shifted = {r_rem[RW-3:0], r_src[IN_BITS-1 -: 2]};
    assign trial   = {{(RW-OUT_BITS-2){1'b0}}, r_root, 2'b01};
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem <= '0;
                r_root <= '0;
                r_src <= i_val;
                r_cnt <= CW'(OUT_BITS);
            end else if (r_busy) begin
                r_src <= {r_src[IN_BITS-3:0], 2'b00};
                if (shifted >= trial) begin
                    r_rem <= shifted - trial;
                    r_root <= {r_root[OUT_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_root <= {r_root[OUT_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/palc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module palc_div #(
    parameter int N_BITS = 74,
    parameter int D_BITS = 33
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [N_BITS-1:0] i_num,
    input  logic [D_BITS-1:0] i_den,
    output logic              o_done,
    output logic [N_BITS-1:0] o_quot
);

    localparam int CW = $clog2(N_BITS + 1);

    logic [N_BITS-1:0] r_q;
    logic [D_BITS:0]   r_rem;
    logic [D_BITS-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic [D_BITS:0]   sh;

    assign sh     = {r_rem[D_BITS-1:0], r_q[N_BITS-1]};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= CW'(N_BITS);
            end else if (r_busy) begin
                if (sh >= {1'b0, r_den}) begin
                    r_rem <= sh - {1'b0, r_den};
                    r_q <= {r_q[N_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q <= {r_q[N_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/palc_back.sv
// Back part: segment length, window tests, interpolation and output register.
module palc_back
    import palc_pkg::*;
#(
    parameter int LB = LENGTH_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  t_job          i_job,
    input  logic [LB-1:0] i_start_dist,
    input  logic [LB-1:0] i_end_dist,
    output logic          o_valid,
    input  logic          i_ready,
    output t_out_item     o_data
);

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int DB  = CB + 1;
    localparam int SB  = 2 * DB;
    localparam int NB  = DB + LB + 1;
    localparam logic [LB-1:0] MIN_SEG = LB'(((64'd1 << FB) + 64'd99999) / 64'd100000);
    localparam logic [LB-1:0] LMAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SQRT, S_WAIT, S_TEST, S_DIVX, S_DIVY,
        S_PUSH, S_OUT
    } t_state;

    t_state             r_state;
    logic signed [CB-1:0] r_px, r_py, r_cx, r_cy, r_lx, r_ly, r_ax, r_ay;
    logic [LB-1:0]      r_run, r_nxt, r_seg, r_off;
    logic               r_started, r_done, r_any, r_hold;
    logic [DB-1:0]      r_mx, r_my;
    logic               r_nx, r_ny;
    logic [SB:0]        r_sq;
    logic               r_sq_go, r_dv_go;
    logic signed [CB-1:0] r_ix, r_iy, r_ox, r_oy;
    logic               r_pclosed, r_phase;
    logic               r_o_closed, r_o_last, r_valid;

    logic               sq_done, dv_done, dup;
    logic [DB:0]        root;
    logic [NB-1:0]      quot, num;
    logic [DB-1:0]      mag;
    logic               mneg;
    logic signed [DB:0] dxs, dys;
    logic [SB-1:0]      sqx, sqy, prod;
    logic [LB:0]        sum;
    logic signed [CB:0] qv;

    assign dxs = DB'(i_job.x) - DB'(r_px);
    assign dys = DB'(i_job.y) - DB'(r_py);
    assign sqx = r_mx * r_mx;
    assign sqy = r_my * r_my;

    palc_sqrt #(.IN_BITS(SB + 2), .OUT_BITS(DB + 1)) u_sqrt (
        .i_clk, .i_rst_n, .i_start(r_sq_go), .i_val({1'b0, r_sq}),
        .o_done(sq_done), .o_root(root)
    );

    assign mag  = (r_state == S_DIVY) ? r_my : r_mx;
    assign mneg = (r_state == S_DIVY) ? r_ny : r_nx;
    assign prod = mag * DB'(r_off);
    assign num  = NB'(prod) + NB'(r_seg >> 1);

    palc_div #(.N_BITS(NB), .D_BITS(LB)) u_div (
        .i_clk, .i_rst_n, .i_start(r_dv_go), .i_num(num), .i_den(r_seg),
        .o_done(dv_done), .o_quot(quot)
    );

    assign qv  = mneg ? -(CB+1)'(quot) : (CB+1)'(quot);
    assign sum = {1'b0, r_run} + {1'b0, r_seg};
    assign dup = r_any && (r_lx == r_ix) && (r_ly == r_iy);

    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_data  = '{out_x: r_ox, out_y: r_oy, is_last: r_o_last,
                       window_closed: r_o_closed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_started <= 1'b0;
            r_done <= 1'b0;
            r_any <= 1'b0;
            r_sq_go <= 1'b0;
            r_dv_go <= 1'b0;
            r_px <= '0; r_py <= '0; r_run <= '0; r_lx <= '0; r_ly <= '0;
        end else begin
            r_sq_go <= 1'b0;
            r_dv_go <= 1'b0;
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid && o_job_ready) begin
                        if (i_job.restart) begin
                            r_px <= i_job.x; r_py <= i_job.y;
                            r_run <= '0;
                            r_started <= 1'b0; r_done <= 1'b0; r_any <= 1'b0;
                        end else if (!r_done) begin
                            r_cx <= i_job.x; r_cy <= i_job.y;
                            r_ax <= r_px; r_ay <= r_py;
                            r_nx <= dxs[DB]; r_ny <= dys[DB];
                            r_mx <= dxs[DB] ? DB'(-dxs) : DB'(dxs);
                            r_my <= dys[DB] ? DB'(-dys) : DB'(dys);
                            r_phase <= 1'b0;
                            r_hold <= 1'b0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_sq <= {1'b0, sqx} + {1'b0, sqy};
                    r_sq_go <= 1'b1;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_px <= r_cx; r_py <= r_cy;
                        r_seg <= LB'(root);
                        r_nxt <= sum[LB] ? LMAX : sum[LB-1:0];
                        if (LB'(root) < MIN_SEG) r_state <= S_IDLE;
                        else r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_nxt <= (sum[LB]) ? LMAX : sum[LB-1:0];
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    if (!r_phase && !r_started && i_start_dist >= r_run
                            && i_start_dist <= r_nxt) begin
                        r_off <= i_start_dist - r_run;
                        r_pclosed <= 1'b0;
                        r_started <= 1'b1;
                        r_dv_go <= 1'b1;
                        r_state <= S_DIVX;
                    end else if (r_started) begin
                        r_phase <= 1'b1;
                        if (i_end_dist >= r_run && i_end_dist <= r_nxt) begin
                            r_off <= i_end_dist - r_run;
                            r_pclosed <= 1'b1;
                            r_done <= 1'b1;
                            r_dv_go <= 1'b1;
                            r_state <= S_DIVX;
                        end else begin
                            r_ix <= r_cx; r_iy <= r_cy;
                            r_pclosed <= 1'b0;
                            r_state <= S_PUSH;
                        end
                    end else begin
                        r_run <= r_nxt;
                        r_state <= S_IDLE;
                    end
                end
                S_DIVX: begin
                    if (dv_done) begin
                        r_ix <= CB'(qv) + r_ax;
                        r_dv_go <= 1'b1;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (dv_done) begin
                        r_iy <= CB'(qv) + r_ay;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!r_phase) begin
                        // hold the start point until the second point is known
                        if (!dup) begin
                            r_lx <= r_ix; r_ly <= r_iy; r_any <= 1'b1;
                            r_hold <= 1'b1;
                        end
                        r_phase <= 1'b1;
                        r_state <= S_TEST;
                    end else if (!r_valid) begin
                        if (!dup) begin
                            r_lx <= r_ix; r_ly <= r_iy; r_any <= 1'b1;
                        end
                        if (r_hold) begin
                            r_ox <= r_lx; r_oy <= r_ly;
                            r_o_closed <= 1'b0;
                            r_o_last <= dup;
                            r_valid <= 1'b1;
                        end else if (!dup) begin
                            r_ox <= r_ix; r_oy <= r_iy;
                            r_o_closed <= r_pclosed;
                            r_o_last <= 1'b1;
                            r_valid <= 1'b1;
                        end
                        r_run <= r_nxt;
                        r_state <= (r_hold && !dup) ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_ox <= r_ix; r_oy <= r_iy;
                        r_o_closed <= r_pclosed;
                        r_o_last <= 1'b1;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> r_valid) else $error("result dropped");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> $stable(o_data)) else $error("result changed while held");
    a_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVX) |-> r_seg >= MIN_SEG) else $error("divide by short segment");

endmodule

FILE: design/polyline_arc_length_clip_unit.sv
// Top level: polyline arc-length window clip.
// Vertices arrive one per beat; a first_vertex beat starts a new polyline. The unit emits the
// part of the polyline between the start and end distance registers, with interpolated points
// at the window boundaries, and drops a point equal to the one emitted just before it. A vertex
// that forms a segment spends most of its time in the back part in a 34-step square root; each
// window boundary on the segment adds two divides of 74 steps. A first vertex, or one after the
// window has closed, is taken by the back part without a square root or divide. The front queue
// holds two vertices while the back works, and the back goes on with the next vertex while a
// result waits. Configuration writes are accepted only while no vertex is queued or in progress.
module polyline_arc_length_clip_unit
    import palc_pkg::*;
#(
    parameter int LB = LENGTH_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_in_item      i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output t_out_item     o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [LB-1:0] i_cfg_data
);

    logic [LB-1:0] r_start, r_end;
    logic          job_valid, job_ready;
    t_job          job;

    assign o_cfg_ready = job_ready && !job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_index'(i_cfg_index))
                REG_START: r_start <= i_cfg_data;
                REG_END:   r_end <= i_cfg_data;
                default:   r_end <= r_end;
            endcase
        end
    end

    palc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    palc_back #(.LB(LB)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_ready(job_ready),
        .i_job(job), .i_start_dist(r_start), .i_end_dist(r_end),
        .o_valid, .i_ready, .o_data
    );

endmodule

FILE: tb/palc_clip_checker.sv
// Checker for the arc-length clip unit: predicts every output beat and compares.
module palc_clip_checker
    import palc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  t_in_item               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  t_out_item              out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [LENGTH_BITS-1:0] cfg_data,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam logic [63:0] MIN_SEG = ((64'd1 << FRAC_BITS) + 64'd99999) / 64'd100000;

    logic [LENGTH_BITS-1:0] win_start, win_end, arc_len;
    logic signed [31:0]     prev_x, prev_y, last_x, last_y;
    bit                     have_prev, started, closed, any_out;
    t_out_item              clipped_q[$];
    t_out_item              beats[$];

    function automatic logic [63:0] seg_sqrt(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= s) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] interp(logic signed [63:0] a, logic signed [63:0] b,
                                                  logic [63:0] off, logic [63:0] len);
        logic signed [63:0] d;
        logic [63:0]        mag;
        logic [127:0]       q;
        d   = b - a;
        mag = (d < 0) ? -d : d;
        q   = (128'(mag) * 128'(off) + 128'(len >> 1)) / 128'(len);
        return 32'((d < 0) ? (a - 64'(q)) : (a + 64'(q)));
    endfunction

    task automatic emit(logic signed [31:0] x, logic signed [31:0] y, bit is_end);
        t_out_item b;
        if (any_out && last_x == x && last_y == y) return;
        b.out_x = x;
        b.out_y = y;
        b.is_last = 1'b0;
        b.window_closed = is_end;
        beats = {beats, b};
        last_x = x;
        last_y = y;
        any_out = 1;
    endtask

    task automatic clip_vertex(t_in_item it);
        logic signed [63:0] ax, ay, bx, by, dx, dy;
        logic [63:0]        mx, my, seg, nxt;
        beats.delete();
        if (it.first_vertex || !have_prev) begin
            prev_x = it.point_x;
            prev_y = it.point_y;
            have_prev = 1;
            arc_len = '0;
            started = 0;
            closed = 0;
            any_out = 0;
            return;
        end
        if (closed) return;
        ax = prev_x;
        ay = prev_y;
        bx = it.point_x;
        by = it.point_y;
        dx = bx - ax;
        dy = by - ay;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        seg = seg_sqrt(128'(mx) * 128'(mx) + 128'(my) * 128'(my));
        prev_x = it.point_x;
        prev_y = it.point_y;
        if (seg < MIN_SEG) return;
        nxt = 64'(arc_len) + seg;
        if (nxt > LEN_MAX) nxt = LEN_MAX;
        if (!started && 64'(win_start) >= 64'(arc_len) && 64'(win_start) <= nxt) begin
            emit(interp(ax, bx, 64'(win_start - arc_len), seg),
                 interp(ay, by, 64'(win_start - arc_len), seg), 0);
            started = 1;
        end
        if (started) begin
            if (64'(win_end) >= 64'(arc_len) && 64'(win_end) <= nxt) begin
                emit(interp(ax, bx, 64'(win_end - arc_len), seg),
                     interp(ay, by, 64'(win_end - arc_len), seg), 1);
                closed = 1;
            end else begin
                emit(it.point_x, it.point_y, 0);
            end
        end
        arc_len = nxt[LENGTH_BITS-1:0];
        if (beats.size() > 0) beats[beats.size()-1].is_last = 1'b1;
        clipped_q = {clipped_q, beats};
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            win_start = '0;
            win_end = '0;
            arc_len = '0;
            prev_x = '0;
            prev_y = '0;
            last_x = '0;
            last_y = '0;
            have_prev = 0;
            started = 0;
            closed = 0;
            any_out = 0;
            clipped_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (t_reg_index'(cfg_index))
                    REG_START: win_start = cfg_data;
                    REG_END:   win_end = cfg_data;
                    default:   win_end = win_end;
                endcase
            end
            if (out_valid && out_ready) begin
                if (clipped_q.size() == 0) begin
                    $error("unexpected beat x=%0d y=%0d", out_data.out_x, out_data.out_y);
                    fail_count++;
                end else begin
                    want = clipped_q.pop_front();
                    if (out_data.out_x !== want.out_x) begin
                        $error("out_x expected %0d got %0d", want.out_x, out_data.out_x);
                        fail_count++;
                    end
                    if (out_data.out_y !== want.out_y) begin
                        $error("out_y expected %0d got %0d", want.out_y, out_data.out_y);
                        fail_count++;
                    end
                    if (out_data.is_last !== want.is_last) begin
                        $error("is_last expected %0d got %0d", want.is_last, out_data.is_last);
                        fail_count++;
                    end
                    if (out_data.window_closed !== want.window_closed) begin
                        $error("window_closed expected %0d got %0d",
                               want.window_closed, out_data.window_closed);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) clip_vertex(in_data);
        end
        pending = clipped_q.size();
    end

endmodule

FILE: tb/polyline_arc_length_clip_unit_tb.sv
// Testbench top: stimulus, flow control and verdict for the arc-length clip unit.
module polyline_arc_length_clip_unit_tb;
    import palc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam logic [39:0] DIST_MAX = '1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    t_in_item               i_data = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    t_out_item              o_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index = REG_START;
    logic [LENGTH_BITS-1:0] i_cfg_data = '0;

    int fail_count, pending;
    int idle_pct = 0, stall_pct = 0, cycles = 0, hold_left = 0;
    bit hold_req = 0, hold_seen = 0;

    polyline_arc_length_clip_unit uut (.*);

    palc_clip_checker chk (
        .clk(i_clk), .rst_n(i_rst_n),
        .in_valid(i_valid), .in_ready(o_ready), .in_data(i_data),
        .out_valid(o_valid), .out_ready(i_ready), .out_data(o_data),
        .cfg_valid(i_cfg_valid), .cfg_ready(o_cfg_ready),
        .cfg_index(i_cfg_index), .cfg_data(i_cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("polyline_arc_length_clip_unit verification failed");
            $finish;
        end
    end

    // hold off the output for a long stretch once per request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_seen) begin
            i_ready <= 1'b0;
            hold_left <= 400;
            hold_seen <= 1;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
        if (!hold_req) hold_seen <= 0;
    end

    task automatic send(logic signed [31:0] x, logic signed [31:0] y, bit first);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid <= 1'b1;
        i_data <= '{point_x: x, point_y: y, first_vertex: first};
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic set_window(logic [39:0] s, logic [39:0] e);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_START;
        i_cfg_data <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_END;
        i_cfg_data <= e;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic rand_polyline();
        logic signed [31:0] x, y;
        int n;
        x = $urandom_range(0, 1 << 22) - (1 << 21);
        y = $urandom_range(0, 1 << 22) - (1 << 21);
        n = $urandom_range(3, 12);
        send(x, y, 1'b1);
        for (int k = 1; k < n; k++) begin
            case ($urandom_range(15))
                0: ;
                1: begin
                    x = $urandom;
                    y = $urandom;
                end
                default: begin
                    x = x + $urandom_range(0, 1 << 21) - (1 << 20);
                    y = y + $urandom_range(0, 1 << 21) - (1 << 20);
                end
            endcase
            send(x, y, 1'b0);
        end
    endtask

    task automatic rand_phase(int idle, int stall, int items, bit squeeze);
        logic [39:0] s;
        logic [39:0] e;
        int sent;
        drain();
        s = $urandom_range(0, 1 << 23);
        e = ($urandom_range(7) == 0) ? 40'($urandom_range(0, 1 << 22))
                                     : s + $urandom_range(0, 1 << 23);
        set_window(s, e);
        idle_pct = idle;
        stall_pct = stall;
        if (squeeze) hold_req <= 1;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(19) == 0) begin
                send($urandom, $urandom, $urandom_range(1));
                sent++;
            end else begin
                rand_polyline();
                sent += 7;
            end
            if (squeeze && sent > 40) hold_req <= 0;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_window('0, DIST_MAX);
        send(32'sd1000, 32'sd2000, 1'b0);
        send(32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send(32'sh80000000, 32'sh80000000, 1'b0);
        send(32'sh80000000, 32'sh80000000, 1'b0);
        send(32'sh80000000, 32'sh7fffffff, 1'b0);
        send(32'sh7fffffff, 32'sh80000000, 1'b0);
        send(32'sh0, 32'sh0, 1'b1);
        send(32'sh0, 32'sh0, 1'b0);
        send(32'sh10000, 32'sh0, 1'b0);

        drain();
        set_window(40'h28000, 40'h28000);
        send(32'sh0, 32'sh0, 1'b1);
        for (int k = 1; k <= 4; k++) send(32'(k << 16), 32'sh0, 1'b0);

        drain();
        set_window(40'h18000, 40'h8000);
        send(32'sh0, 32'sh0, 1'b1);
        for (int k = 1; k <= 4; k++) send(32'sh0, -32'(k << 16), 1'b0);

        drain();
        set_window(DIST_MAX, DIST_MAX);
        send(32'sh80000000, 32'sh80000000, 1'b1);
        for (int k = 0; k < 200; k++)
            send(k[0] ? 32'sh80000000 : 32'sh7fffffff,
                 k[0] ? 32'sh80000000 : 32'sh7fffffff, 1'b0);

        rand_phase(0, 0, 45, 0);
        rand_phase(77, 0, 45, 0);
        rand_phase(0, 77, 45, 1);
        rand_phase(12, 12, 45, 0);

        drain();
        if (fail_count == 0) begin
            $display("polyline_arc_length_clip_unit verification clean");
        end else begin
            $display("polyline_arc_length_clip_unit verification failed");
        end
        $finish;
    end

endmodule
